FILE: hw/rtl/pre_pkg.sv
`timescale 1ns / 1ps

package pre_pkg;

  // Sizing of the stores.
  localparam int TABLE_MAX  = 64;
  localparam int POOL_MAX   = 64;
  localparam int FRAME_BITS = 8;
  localparam int TIME_BITS  = 32;
  localparam int USES_BITS  = 32;

  localparam int PAGE_W  = (TABLE_MAX > 1) ? $clog2(TABLE_MAX) : 1;
  localparam int POOL_AW = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
  localparam int FILL_W  = $clog2(POOL_MAX + 1);

  // Configuration register layout.
  localparam int POLICY_W = 2;
  localparam int TCOUNT_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Width wide enough to compare the table count register, a page number and TABLE_MAX.
  localparam int CNT_W_RAW = $clog2(TABLE_MAX + 1);
  localparam int CMP_W     = (CNT_W_RAW > TCOUNT_W) ? CNT_W_RAW : TCOUNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT = CFG_IDX_W'(1);

  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_LFU  = 2'd2;

  localparam logic [TCOUNT_W-1:0] TABLE_COUNT_RST = TCOUNT_W'(64);

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_PUSH   = 1'b1;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_FREE_USED = 3'd1;
  localparam logic [2:0] ST_REPLACED  = 3'd2;
  localparam logic [2:0] ST_NO_FRAME  = 3'd3;
  localparam logic [2:0] ST_PUSHED    = 3'd4;
  localparam logic [2:0] ST_POOL_FULL = 3'd5;
  localparam logic [2:0] ST_RANGE     = 3'd6;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [TIME_BITS-1:0]  arrival;
    logic [TIME_BITS-1:0]  last_use;
    logic [USES_BITS-1:0]  uses;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/pre_ram.sv
`timescale 1ns / 1ps

module pre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/page_replacement_engine_core.sv
`timescale 1ns / 1ps

// Demand-paging frame assigner with FIFO, LRU and LFU replacement.
//
// A request is taken at a rising edge where start is high and busy is low.
// A page access hits, takes the oldest frame of the free pool, or evicts the
// policy's victim and reuses its frame, else fails as out of range or no frame.
// A push request appends a frame to the free pool. Each request yields exactly
// one result, shown on frame_out_o, status_o and victim_page_o for one cycle
// with done_o high. The receiver cannot stall; results are never held back.
//
// A push or an out-of-range page has its result registered at the accepting
// edge. A hit or a free-frame miss first does one read of the page table or
// pool memory and registers the result from the read data. A replacement
// scans the entries in use and commits the eviction in a final state. The
// scan reads one page table entry per cycle through the single memory read
// port and feeds it to one shared victim comparator. Busy drops as the result
// is registered, so a new request may be taken in the done cycle. Reset clears
// every page valid bit, empties the pool, and sets policy FIFO with 64 entries
// in use; memory contents are not cleared. The configuration channel is always
// ready; the user must write it only while the block is idle (not enforced).

module page_replacement_engine_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pre_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pre_pkg::CFG_DATA_W-1:0]     cfg_data_i,

  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [pre_pkg::PAGE_W-1:0]         page_number_i,
  input  logic [pre_pkg::FRAME_BITS-1:0]     frame_in_i,
  input  logic [pre_pkg::TIME_BITS-1:0]      timestamp_i,

  output logic                               done_o,
  output logic [pre_pkg::FRAME_BITS-1:0]     frame_out_o,
  output logic [2:0]                         status_o,
  output logic [pre_pkg::PAGE_W-1:0]         victim_page_o
);

  import pre_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HIT  = 3'd1;
  localparam logic [2:0] S_POOL = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [POLICY_W-1:0] policy_q;
  logic [TCOUNT_W-1:0] tcount_q;

  // Page valid bits and pool pointers.
  logic [TABLE_MAX-1:0] valid_q, valid_d;
  logic [POOL_AW-1:0]   head_q, head_d;
  logic [FILL_W-1:0]    fill_q, fill_d;

  // Captured request.
  logic [PAGE_W-1:0]    page_q, page_d;
  logic [TIME_BITS-1:0] ts_q, ts_d;

  // Scan bookkeeping and the best candidate so far.
  logic [CMP_W-1:0]      scan_idx_q, scan_idx_d;
  logic                  pend_q, pend_d;
  logic [PAGE_W-1:0]     pend_idx_q, pend_idx_d;
  logic                  found_q, found_d;
  logic [PAGE_W-1:0]     best_idx_q, best_idx_d;
  entry_t                best_q, best_d;

  // Result registers.
  logic                  done_q, done_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [2:0]            status_q, status_d;
  logic [PAGE_W-1:0]     victim_q, victim_d;

  // Memory ports.
  logic              tbl_we;
  logic [PAGE_W-1:0] tbl_waddr, tbl_raddr;
  entry_t            tbl_wdata, tbl_rdata;
  logic              pool_we;
  logic [POOL_AW-1:0] pool_waddr;
  logic [FRAME_BITS-1:0] pool_rdata;

  logic [CMP_W-1:0]   used_cnt;
  logic [CMP_W-1:0]   tc_ext;
  logic [FILL_W:0]    slot_sum;
  logic [POOL_AW-1:0] slot;
  logic [POOL_AW-1:0] head_next;
  logic               better;
  logic [USES_BITS-1:0] uses_inc;
  entry_t             fresh;

  // Entries at or beyond the table count are invisible.
  assign tc_ext   = CMP_W'(tcount_q);
  assign used_cnt = (tc_ext > CMP_W'(TABLE_MAX)) ? CMP_W'(TABLE_MAX) : tc_ext;

  assign slot_sum = (FILL_W + 1)'(head_q) + (FILL_W + 1)'(fill_q);
  assign slot = (slot_sum >= (FILL_W + 1)'(POOL_MAX)) ?
                POOL_AW'(slot_sum - (FILL_W + 1)'(POOL_MAX)) : POOL_AW'(slot_sum);
  assign head_next = (head_q == POOL_AW'(POOL_MAX - 1)) ? '0 : head_q + POOL_AW'(1);

  assign uses_inc = (&tbl_rdata.uses) ? tbl_rdata.uses : tbl_rdata.uses + USES_BITS'(1);

  // Shared victim comparator: is the entry just read a better victim than the best one?
  always_comb begin
    case (policy_q)
      POL_LRU: better = tbl_rdata.last_use < best_q.last_use;
      POL_LFU: better = (tbl_rdata.uses < best_q.uses) ||
                        ((tbl_rdata.uses == best_q.uses) &&
                         (tbl_rdata.arrival < best_q.arrival));
      default: better = tbl_rdata.arrival < best_q.arrival;
    endcase
  end

  always_comb begin
    fresh.frame    = '0;
    fresh.arrival  = ts_q;
    fresh.last_use = ts_q;
    fresh.uses     = USES_BITS'(1);
  end

  assign tbl_raddr = (state_q == S_SCAN) ? scan_idx_q[PAGE_W-1:0] : page_number_i;

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    head_d     = head_q;
    fill_d     = fill_q;
    page_d     = page_q;
    ts_d       = ts_q;
    scan_idx_d = scan_idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    done_d     = 1'b0;
    frame_d    = frame_q;
    status_d   = status_q;
    victim_d   = victim_q;
    tbl_we     = 1'b0;
    tbl_waddr  = page_q;
    tbl_wdata  = fresh;
    pool_we    = 1'b0;
    pool_waddr = slot;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          page_d   = page_number_i;
          ts_d     = timestamp_i;
          frame_d  = '0;
          victim_d = '0;
          if (operation_i == OP_PUSH) begin
            done_d = 1'b1;
            if (fill_q >= FILL_W'(POOL_MAX)) begin
              status_d = ST_POOL_FULL;
            end else begin
              pool_we  = 1'b1;
              fill_d   = fill_q + FILL_W'(1);
              status_d = ST_PUSHED;
            end
          end else if (CMP_W'(page_number_i) >= used_cnt) begin
            done_d   = 1'b1;
            status_d = ST_RANGE;
          end else if (valid_q[page_number_i]) begin
            state_d = S_HIT;
          end else if (fill_q != '0) begin
            state_d = S_POOL;
          end else begin
            state_d    = S_SCAN;
            scan_idx_d = '0;
            pend_d     = 1'b0;
            found_d    = 1'b0;
          end
        end
      end
      S_HIT: begin
        tbl_we             = 1'b1;
        tbl_wdata          = tbl_rdata;
        tbl_wdata.last_use = ts_q;
        tbl_wdata.uses     = uses_inc;
        frame_d            = tbl_rdata.frame;
        status_d           = ST_HIT;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end
      S_POOL: begin
        tbl_we          = 1'b1;
        tbl_wdata.frame = pool_rdata;
        valid_d[page_q] = 1'b1;
        head_d          = head_next;
        fill_d          = fill_q - FILL_W'(1);
        frame_d         = pool_rdata;
        status_d        = ST_FREE_USED;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end
      S_SCAN: begin
        // Data for the entry read last cycle arrives now.
        if (pend_q && valid_q[pend_idx_q] && (!found_q || better)) begin
          found_d    = 1'b1;
          best_idx_d = pend_idx_q;
          best_d     = tbl_rdata;
        end
        if (scan_idx_q < used_cnt) begin
          pend_d     = 1'b1;
          pend_idx_d = scan_idx_q[PAGE_W-1:0];
          scan_idx_d = scan_idx_q + CMP_W'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (!found_q) begin
          status_d = ST_NO_FRAME;
        end else begin
          tbl_we              = 1'b1;
          tbl_wdata.frame     = best_q.frame;
          valid_d[best_idx_q] = 1'b0;
          valid_d[page_q]     = 1'b1;
          frame_d             = best_q.frame;
          victim_d            = best_idx_q;
          status_d            = ST_REPLACED;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      policy_q <= POL_FIFO;
      tcount_q <= TABLE_COUNT_RST;
      valid_q  <= '0;
      head_q   <= '0;
      fill_q   <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_POLICY) begin
          policy_q <= cfg_data_i[POLICY_W-1:0];
        end else if (cfg_index_i == CFG_TABLE_COUNT) begin
          tcount_q <= cfg_data_i[TCOUNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    ts_q       <= ts_d;
    scan_idx_q <= scan_idx_d;
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    frame_q    <= frame_d;
    status_q   <= status_d;
    victim_q   <= victim_d;
  end

  pre_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_MAX)
  ) u_table_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  pre_ram #(
    .WIDTH(FRAME_BITS),
    .DEPTH(POOL_MAX)
  ) u_pool_ram (
    .clk_i  (clk_i),
    .we_i   (pool_we),
    .waddr_i(pool_waddr),
    .wdata_i(frame_in_i),
    .raddr_i(head_q),
    .rdata_o(pool_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign frame_out_o   = frame_q;
  assign status_o      = status_q;
  assign victim_page_o = victim_q;

  // The pool never holds more frames than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FILL_W'(POOL_MAX))
    else $error("free pool fill count overflow");

  // The scan never reads past the entries in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_SCAN) |-> (scan_idx_q <= used_cnt))
    else $error("victim scan ran past the table count");

  // A reported victim has lost its mapping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_q && (status_q == ST_REPLACED)) |-> !valid_q[victim_q])
    else $error("evicted page is still valid");

  // A push request completes without leaving the sequencer busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_IDLE && start && operation_i == OP_PUSH) |=> !busy)
    else $error("push request left the sequencer busy");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pre_pkg::*;

  // Policy code 3 has no name in the package; the engine treats it as FIFO.
  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOT_PAGES       = 16;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [2:0]            status;
    logic [PAGE_W-1:0]     victim;
  } page_result_t;

  // One line of the directed script: either a register write or a request,
  // optionally with its result spelled out by hand.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  op;
    logic [PAGE_W-1:0]     page;
    logic [FRAME_BITS-1:0] frame_in;
    logic [TIME_BITS-1:0]  stamp;
    bit                    typed;
    page_result_t          result;
  } script_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  start     = 1'b0;
  logic                  busy;
  logic                  operation = OP_ACCESS;
  logic [PAGE_W-1:0]     page      = '0;
  logic [FRAME_BITS-1:0] frame_in  = '0;
  logic [TIME_BITS-1:0]  stamp     = '0;
  logic                  done;
  logic [FRAME_BITS-1:0] frame_out;
  logic [2:0]            status;
  logic [PAGE_W-1:0]     victim_page;

  page_replacement_engine_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation),
    .page_number_i (page),
    .frame_in_i    (frame_in),
    .timestamp_i   (stamp),
    .done_o        (done),
    .frame_out_o   (frame_out),
    .status_o      (status),
    .victim_page_o (victim_page)
  );

  always #2 clk = ~clk;

  // Shadow copy of the page table, the free pool and both registers.
  logic                  pt_valid    [TABLE_MAX];
  logic [FRAME_BITS-1:0] pt_frame    [TABLE_MAX];
  logic [TIME_BITS-1:0]  pt_arrival  [TABLE_MAX];
  logic [TIME_BITS-1:0]  pt_last_use [TABLE_MAX];
  logic [USES_BITS-1:0]  pt_uses     [TABLE_MAX];
  logic [FRAME_BITS-1:0] pool        [POOL_MAX];
  logic [POOL_AW-1:0]    pool_head;
  logic [FILL_W-1:0]     pool_fill;
  logic [POLICY_W-1:0]   policy;
  logic [TCOUNT_W-1:0]   table_count;

  page_result_t expected_results [$];
  page_result_t oldest;
  int           mismatch_count = 0;
  int           stall_cycles   = 0;

  // A count register above the table size simply means the whole table.
  function automatic int entries_in_use();
    return (table_count > TABLE_MAX) ? TABLE_MAX : int'(table_count);
  endfunction

  function automatic void map_page(logic [PAGE_W-1:0] pg, logic [FRAME_BITS-1:0] fr,
                                   logic [TIME_BITS-1:0] ts);
    pt_valid[pg]    = 1'b1;
    pt_frame[pg]    = fr;
    pt_arrival[pg]  = ts;
    pt_last_use[pg] = ts;
    pt_uses[pg]     = USES_BITS'(1);
  endfunction

  // Applies one request to the shadow state and returns the result the
  // engine has to produce for it.
  function automatic page_result_t assign_frame(logic op_v, logic [PAGE_W-1:0] pg,
                                                logic [FRAME_BITS-1:0] fr,
                                                logic [TIME_BITS-1:0] ts);
    page_result_t r;
    int           n;
    int           best;
    bit           found;
    bit           better;
    r = '0;
    n = entries_in_use();
    if (op_v == OP_PUSH) begin
      if (pool_fill >= POOL_MAX) begin
        r.status = ST_POOL_FULL;
      end else begin
        pool[pool_head + POOL_AW'(pool_fill)] = fr;
        pool_fill = pool_fill + FILL_W'(1);
        r.status  = ST_PUSHED;
      end
    end else if (int'(pg) >= n) begin
      r.status = ST_RANGE;
    end else if (pt_valid[pg]) begin
      pt_last_use[pg] = ts;
      if (pt_uses[pg] != '1) begin
        pt_uses[pg] = pt_uses[pg] + USES_BITS'(1);
      end
      r.frame  = pt_frame[pg];
      r.status = ST_HIT;
    end else if (pool_fill != 0) begin
      r.frame   = pool[pool_head];
      pool_head = pool_head + POOL_AW'(1);
      pool_fill = pool_fill - FILL_W'(1);
      map_page(pg, r.frame, ts);
      r.status = ST_FREE_USED;
    end else begin
      // Pool is empty: scan the entries in use for the victim. Strict
      // comparisons leave remaining ties with the lowest page index.
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < n; i++) begin
        if (pt_valid[i]) begin
          case (policy)
            POL_LRU: begin
              better = pt_last_use[i] < pt_last_use[best];
            end
            POL_LFU: begin
              if (pt_uses[i] != pt_uses[best]) begin
                better = pt_uses[i] < pt_uses[best];
              end else begin
                better = pt_arrival[i] < pt_arrival[best];
              end
            end
            default: begin
              better = pt_arrival[i] < pt_arrival[best];
            end
          endcase
          if (!found || better) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        r.status = ST_NO_FRAME;
      end else begin
        r.frame        = pt_frame[best];
        pt_valid[best] = 1'b0;
        map_page(pg, r.frame, ts);
        r.victim = PAGE_W'(best);
        r.status = ST_REPLACED;
      end
    end
    return r;
  endfunction

  function automatic script_row_t item(logic op_v, logic [PAGE_W-1:0] pg,
                                       logic [FRAME_BITS-1:0] fr, logic [TIME_BITS-1:0] ts);
    script_row_t row;
    row          = '{default: '0};
    row.op       = op_v;
    row.page     = pg;
    row.frame_in = fr;
    row.stamp    = ts;
    return row;
  endfunction

  // A request whose result is obvious; the victim field is zero in all of them.
  function automatic script_row_t item_with(logic op_v, logic [PAGE_W-1:0] pg,
                                            logic [FRAME_BITS-1:0] fr,
                                            logic [TIME_BITS-1:0] ts,
                                            logic [2:0] st, logic [FRAME_BITS-1:0] fr_out);
    script_row_t row;
    row               = item(op_v, pg, fr, ts);
    row.typed         = 1'b1;
    row.result.status = st;
    row.result.frame  = fr_out;
    return row;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    script_row_t row;
    row           = '{default: '0};
    row.is_cfg    = 1'b1;
    row.cfg_index = idx;
    row.cfg_data  = data;
    return row;
  endfunction

  // Presents one request at the falling edge and holds it until the engine
  // takes it; start stays high so a following request can go out back to back.
  task automatic send_request(logic op_v, logic [PAGE_W-1:0] pg, logic [FRAME_BITS-1:0] fr,
                              logic [TIME_BITS-1:0] ts, bit typed, page_result_t typed_res);
    page_result_t predicted;
    @(negedge clk);
    start     = 1'b1;
    operation = op_v;
    page      = pg;
    frame_in  = fr;
    stamp     = ts;
    do @(posedge clk); while (busy);
    predicted = assign_frame(op_v, pg, fr, ts);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Registers only change while the engine is idle with nothing outstanding.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POLICY) begin
      policy = data[POLICY_W-1:0];
    end else if (idx == CFG_TABLE_COUNT) begin
      table_count = data;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Every result is taken at the edge that ends its strobe cycle and compared
  // against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result frame %0d status %0d victim %0d",
                 $time, frame_out, status, victim_page);
        mismatch_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (frame_out !== oldest.frame) begin
          $display("%0t: frame_out expected %0d actual %0d", $time, oldest.frame, frame_out);
          mismatch_count++;
        end
        if (status !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.status, status);
          mismatch_count++;
        end
        if (victim_page !== oldest.victim) begin
          $display("%0t: victim_page expected %0d actual %0d",
                   $time, oldest.victim, victim_page);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any accepted request, result or register write restarts it.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL page_replacement_engine_core");
      $finish;
    end
  end

  initial begin
    script_row_t           script [$];
    int                    gap_pct  [RANDOM_PHASES];
    int                    push_pct [RANDOM_PHASES];
    int                    n;
    int                    roll;
    int                    gap;
    logic                  op_v;
    logic [PAGE_W-1:0]     pg;
    logic [FRAME_BITS-1:0] fr;
    logic [TIME_BITS-1:0]  ts;
    logic [TIME_BITS-1:0]  clock_now;
    logic [CFG_DATA_W-1:0] tc;

    gap_pct  = '{0, 57, 31, 0, 57, 31, 0, 57};
    push_pct = '{35, 70, 10, 40, 65, 5, 30, 20};
    for (int i = 0; i < TABLE_MAX; i++) begin
      pt_valid[i] = 1'b0;
    end
    pool_head   = '0;
    pool_fill   = '0;
    policy      = POL_FIFO;
    table_count = TABLE_COUNT_RST;
    clock_now   = 32'd1000;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Starts from reset state: FIFO, whole table, empty pool.
    script.push_back(item_with(OP_ACCESS, 6'd0, 8'd0, 32'h10, ST_NO_FRAME, 8'd0));
    script.push_back(item_with(OP_ACCESS, 6'd63, 8'hff, '1, ST_NO_FRAME, 8'd0));
    script.push_back(item_with(OP_PUSH, 6'd0, 8'd0, 32'd0, ST_PUSHED, 8'd0));
    script.push_back(item_with(OP_PUSH, 6'd63, 8'hff, '1, ST_PUSHED, 8'd0));
    script.push_back(item_with(OP_ACCESS, 6'd0, 8'd0, 32'd0, ST_FREE_USED, 8'd0));
    script.push_back(item_with(OP_ACCESS, 6'd63, 8'd0, '1, ST_FREE_USED, 8'hff));
    script.push_back(item_with(OP_ACCESS, 6'd0, 8'd0, 32'd5, ST_HIT, 8'd0));
    // The pool is dry now, so the next miss evicts the oldest arrival.
    script.push_back(item(OP_ACCESS, 6'd42, 8'd0, 32'd100));
    // With no entries in use every access is out of range; pushes still work.
    script.push_back(reg_row(CFG_TABLE_COUNT, 7'd0));
    script.push_back(item_with(OP_ACCESS, 6'd0, 8'd0, 32'd9, ST_RANGE, 8'd0));
    script.push_back(item_with(OP_PUSH, 6'd0, 8'ha5, 32'd9, ST_PUSHED, 8'd0));
    script.push_back(reg_row(CFG_TABLE_COUNT, 7'd127));
    script.push_back(item(OP_ACCESS, 6'd63, 8'd0, 32'd7));
    script.push_back(reg_row(CFG_POLICY, CFG_DATA_W'(POL_LRU)));
    script.push_back(item(OP_ACCESS, 6'd21, 8'd0, 32'd200));
    script.push_back(item(OP_ACCESS, 6'd13, 8'd0, 32'd300));
    script.push_back(reg_row(CFG_POLICY, CFG_DATA_W'(POL_LFU)));
    script.push_back(item(OP_ACCESS, 6'd42, 8'd0, 32'd400));
    script.push_back(item(OP_ACCESS, 6'd13, 8'd0, 32'd500));
    script.push_back(item(OP_ACCESS, 6'd50, 8'd0, 32'd600));
    script.push_back(reg_row(CFG_POLICY, CFG_DATA_W'(POL_SPARE)));
    script.push_back(item(OP_ACCESS, 6'd1, 8'd0, 32'd700));
    // A single entry in use: valid pages above it must be neither hit nor evicted.
    script.push_back(reg_row(CFG_TABLE_COUNT, 7'd1));
    script.push_back(item_with(OP_ACCESS, 6'd1, 8'd0, 32'd1, ST_RANGE, 8'd0));
    script.push_back(item_with(OP_ACCESS, 6'd0, 8'd0, 32'd1, ST_NO_FRAME, 8'd0));

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_reg(script[i].cfg_index, script[i].cfg_data);
      end else begin
        send_request(script[i].op, script[i].page, script[i].frame_in, script[i].stamp,
                     script[i].typed, script[i].result);
      end
    end

    // Random part. Each phase picks a new policy and table size, a push mix
    // that either fills the pool or drains it into replacements, and its own
    // amount of sender idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(CFG_POLICY, CFG_DATA_W'($urandom_range(0, 3)));
      roll = $urandom_range(0, 15);
      if (roll == 0) begin
        tc = '0;
      end else if (roll < 5) begin
        tc = CFG_DATA_W'($urandom_range(1, 8));
      end else if (roll < 10) begin
        tc = CFG_DATA_W'(TABLE_MAX);
      end else begin
        tc = CFG_DATA_W'($urandom_range(1, 127));
      end
      write_reg(CFG_TABLE_COUNT, tc);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        n    = entries_in_use();
        op_v = ($urandom_range(0, 99) < push_pct[ph]) ? OP_PUSH : OP_ACCESS;
        fr   = FRAME_BITS'($urandom_range(0, 255));

        // Mostly a small hot set so that hits and evictions both happen often.
        roll = $urandom_range(0, 99);
        if (n == 0 || roll < 10) begin
          pg = PAGE_W'($urandom_range(0, TABLE_MAX - 1));
        end else if (roll < 65) begin
          pg = PAGE_W'($urandom_range(0, ((n < HOT_PAGES) ? n : HOT_PAGES) - 1));
        end else begin
          pg = PAGE_W'($urandom_range(0, n - 1));
        end

        // A slowly rising clock gives plenty of equal times, hence policy ties.
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          clock_now = clock_now + TIME_BITS'($urandom_range(0, 3));
          ts = clock_now;
        end else if (roll < 75) begin
          ts = $urandom();
        end else if (roll < 85) begin
          ts = '0;
        end else if (roll < 92) begin
          ts = '1;
        end else begin
          ts = clock_now;
        end

        send_request(op_v, pg, fr, ts, 1'b0, '0);

        if ($urandom_range(0, 99) < gap_pct[ph]) begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 70) : $urandom_range(1, 3);
          @(negedge clk);
          start = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS page_replacement_engine_core");
    end else begin
      $display("FAIL page_replacement_engine_core");
    end
    $finish;
  end

endmodule

FILE: page_replacement_engine_core.f
hw/rtl/pre_pkg.sv
hw/rtl/pre_ram.sv
hw/rtl/page_replacement_engine_core.sv
tb/tb.sv
